[sv/lifestep_pkg.sv]
// Shared types, grid constants and the cell rule for the life generation step block.
package lifestep_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SURVIVE_LOW  = 2'd0,
        REG_SURVIVE_HIGH = 2'd1,
        REG_BIRTH_LOW    = 2'd2,
        REG_BIRTH_HIGH   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CELL,
        BK_LOAD,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       set_alive;
    } t_in_item;

    typedef struct packed {
        logic cell_alive;
        logic done_res;
    } t_out_item;

    // Decoded operation handed from the front to the back.
    typedef struct packed {
        t_cmd             kind;
        logic             on_grid;
        logic [ROW_W-1:0] row_idx;
        logic [COL_W-1:0] col_idx;
        logic             set_alive;
    } t_op;

    typedef struct packed {
        logic [3:0] survive_low;
        logic [3:0] survive_high;
        logic [3:0] birth_low;
        logic [3:0] birth_high;
    } t_rules;

    // Next state of one cell from its eight neighbours.
    function automatic logic f_next_cell(input logic [7:0] nbr, input logic alive,
                                         input t_rules rules);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, nbr[k]};
        end
        if (alive) begin
            return (cnt >= rules.survive_low) && (cnt <= rules.survive_high);
        end
        return (cnt >= rules.birth_low) && (cnt <= rules.birth_high);
    endfunction

endpackage

[sv/lifestep_front.sv]
// Front end: accepts input transactions, decodes them and queues the decoded operations.
module lifestep_front
    import lifestep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_clearing,
    output logic     o_op_valid,
    output t_op      o_op,
    input  logic     i_op_take
);

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_op        op_dec;
    logic       push_acc;

    // Classify: bounds check against the grid, then narrow the indexes.
    always_comb begin
        op_dec.kind      = t_cmd'(i_item.cmd);
        op_dec.on_grid   = (32'(i_item.cell_row) < GRID_ROWS) &&
                           (32'(i_item.cell_col) < GRID_COLS);
        op_dec.row_idx   = ROW_W'(i_item.cell_row);
        op_dec.col_idx   = COL_W'(i_item.cell_col);
        op_dec.set_alive = i_item.set_alive;
    end

    assign o_full     = (r_cnt == 2'd2) || i_clearing;
    assign push_acc   = i_push && !o_full;
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rp];
    assign n_cnt      = r_cnt + {1'b0, push_acc} - {1'b0, i_op_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push_acc) begin
                r_wp <= ~r_wp;
            end
            if (i_op_take) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_q[r_wp] <= op_dec;
        end
    end

endmodule

[sv/lifestep_back.sv]
// Back end: grid row memory, clearing pass, cell access and row-wide generation sweep.
module lifestep_back
    import lifestep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    input  t_op       i_op,
    output logic      o_op_take,
    input  t_rules    i_rules,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res,
    output logic      o_clearing
);

    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(GRID_ROWS - 1);
    localparam logic [ROW_W-1:0] PRELAST_ROW = ROW_W'(GRID_ROWS - 2);

    logic [GRID_COLS-1:0] r_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd_data;

    t_back_state          r_state, n_state;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [GRID_COLS-1:0] r_above, n_above, r_mid, n_mid;
    t_op                  r_op, n_op;

    logic                 rd_en, wr_en;
    logic [ROW_W-1:0]     rd_addr, wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic [GRID_COLS-1:0] below, new_row, cell_row_mod;
    logic [GRID_COLS+1:0] pad_above, pad_mid, pad_below;

    // Row below the current one; beyond the last row the grid is dead.
    assign below = (r_row == LAST_ROW) ? '0 : r_rd_data;

    // One lane per column; the padding bits stand for dead cells off the edge.
    always_comb begin
        pad_above = {1'b0, r_above, 1'b0};
        pad_mid   = {1'b0, r_mid, 1'b0};
        pad_below = {1'b0, below, 1'b0};
        for (int c = 0; c < GRID_COLS; c++) begin
            new_row[c] = f_next_cell({pad_above[c+2], pad_above[c+1], pad_above[c],
                                      pad_mid[c+2], pad_mid[c],
                                      pad_below[c+2], pad_below[c+1], pad_below[c]},
                                     r_mid[c], i_rules);
        end
    end

    always_comb begin
        cell_row_mod                = r_rd_data;
        cell_row_mod[r_op.col_idx]  = r_op.set_alive;
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_above    = r_above;
        n_mid      = r_mid;
        n_op       = r_op;
        o_op_take  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_row;
        wr_en      = 1'b0;
        wr_addr    = r_row;
        wr_data    = '0;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            BK_CLEAR: begin
                wr_en = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = BK_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            BK_IDLE: begin
                if (i_op_valid && !i_res_full) begin
                    o_op_take = 1'b1;
                    n_op      = i_op;
                    case (i_op.kind)
                        CMD_WRITE, CMD_READ: begin
                            if (i_op.on_grid) begin
                                rd_en   = 1'b1;
                                rd_addr = i_op.row_idx;
                                n_state = BK_CELL;
                            end else begin
                                o_res_push     = 1'b1;
                                o_res.done_res = 1'b1;
                            end
                        end
                        CMD_STEP: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = BK_LOAD;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            BK_CELL: begin
                o_res_push     = 1'b1;
                o_res.done_res = 1'b1;
                if (r_op.kind == CMD_READ) begin
                    o_res.cell_alive = r_rd_data[r_op.col_idx];
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_op.row_idx;
                    wr_data = cell_row_mod;
                end
                n_state = BK_IDLE;
            end
            BK_LOAD: begin
                n_above = '0;
                n_mid   = r_rd_data;
                n_row   = '0;
                rd_en   = 1'b1;
                rd_addr = ROW_W'(1);
                n_state = BK_RUN;
            end
            BK_RUN: begin
                // Old rows sit in the window, so the new row overwrites in place.
                wr_en   = 1'b1;
                wr_addr = r_row;
                wr_data = new_row;
                n_above = r_mid;
                n_mid   = below;
                if (r_row < PRELAST_ROW) begin
                    rd_en   = 1'b1;
                    rd_addr = r_row + ROW_W'(2);
                end
                if (r_row == LAST_ROW) begin
                    o_res_push     = 1'b1;
                    o_res.done_res = 1'b1;
                    n_state        = BK_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_clearing = (r_state == BK_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_above <= n_above;
        r_mid   <= n_mid;
        r_op    <= n_op;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_grid[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_grid[rd_addr];
        end
    end

endmodule

[sv/lifestep_resq.sv]
// Two-entry result queue that drives the output side.
module lifestep_resq
    import lifestep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    t_out_item  r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       pop_acc;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_q[r_rp];
    assign pop_acc = i_pop && !o_empty;
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, pop_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_acc) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

[sv/life_automaton_generation_step.sv]
// Top level of the life automaton generation step block: rule registers and unit wiring.
//
// Holds a GRID_ROWS by GRID_COLS grid of one-bit cells (64 by 64 by default) as one memory
// row per grid row, and runs three commands pushed in as queue transactions: write a cell,
// read a cell, and advance one generation under the birth and survive ranges held in the
// four APB registers (reset B3/S23). Every transaction gives exactly one result; an unused
// command gives done_res 0, and a cell address off the grid is ignored but still reports
// done. After reset the block sweeps the grid clear, one row per cycle, and holds full high
// until that pass ends; configuration writes are taken as ever. A decoded command waits
// in a two-entry queue, and results wait in a two-entry queue, so a push is taken while
// a finished result is still waiting to be popped. Steps of the back end, which works on
// one command at a time: a cell read or write reads the row, then selects the bit or
// writes back the modified row; an unused command or an address off the grid finishes
// in the idle state; a generation step reads row 0, loads the window, then sweeps one
// grid row per cycle, set by the one read port and one write port of the row memory.
// Each command is also registered in the front queue. Write the rule registers only
// while no transaction is outstanding.
module life_automaton_generation_step
    import lifestep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Rule registers.
    logic [3:0] r_survive_low, r_survive_high, r_birth_low, r_birth_high;
    t_rules     rules;
    logic       cfg_wr;
    t_reg_idx   reg_idx;

    // Front to back and back to result queue.
    logic      clearing;
    logic      op_valid, op_take;
    t_op       op;
    logic      res_push, res_full;
    t_out_item res;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_survive_low  <= 4'd2;
            r_survive_high <= 4'd3;
            r_birth_low    <= 4'd3;
            r_birth_high   <= 4'd3;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SURVIVE_LOW:  r_survive_low  <= pwdata[3:0];
                REG_SURVIVE_HIGH: r_survive_high <= pwdata[3:0];
                REG_BIRTH_LOW:    r_birth_low    <= pwdata[3:0];
                REG_BIRTH_HIGH:   r_birth_high   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        case (reg_idx)
            REG_SURVIVE_LOW:  prdata = {28'd0, r_survive_low};
            REG_SURVIVE_HIGH: prdata = {28'd0, r_survive_high};
            REG_BIRTH_LOW:    prdata = {28'd0, r_birth_low};
            REG_BIRTH_HIGH:   prdata = {28'd0, r_birth_high};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        rules.survive_low  = r_survive_low;
        rules.survive_high = r_survive_high;
        rules.birth_low    = r_birth_low;
        rules.birth_high   = r_birth_high;
    end

    // Accept and classify transactions; hold them until the back end is free.
    lifestep_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .o_full     (full),
        .i_clearing (clearing),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_take  (op_take)
    );

    // Carry out each operation on the grid memory; only start one when a result slot is free.
    lifestep_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_take  (op_take),
        .i_rules    (rules),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res),
        .o_clearing (clearing)
    );

    // Hold finished results until popped.
    lifestep_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_out_item)
    );

endmodule

[sv/lifestep_chk.sv]
// Port-level checker for the life generation step block, bound to the top level.
module lifestep_chk
    import lifestep_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input t_in_item    i_in_item,
    input logic        empty,
    input logic        pop,
    input t_out_item   o_out_item,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // Reset starts the clearing pass with nothing queued.
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("input side open or result pending after reset");

    // A waiting result holds until popped.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("waiting result changed before pop");

    // Only a completed operation may report a live cell.
    a_alive_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_item.done_res |-> !o_out_item.cell_alive)
        else $error("cell_alive set on an operation that did not complete");

    // A rule register reads back what was last written to it.
    a_reg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(psel && penable && pwrite && pready) && $past(i_rst_n) &&
        (paddr[3:2] == $past(paddr[3:2]))
        |-> prdata[3:0] == $past(pwdata[3:0]))
        else $error("rule register read back differs from write");

endmodule

bind life_automaton_generation_step lifestep_chk u_lifestep_chk (.*);

[bench/testbench.sv]
// Self-checking testbench for the life automaton generation step block.
`timescale 1ns / 1ps

module testbench;
    import lifestep_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int WINDOW      = 8;

    // Scoreboard: a cycle-free copy of the grid and the rule ranges. Every accepted
    // transaction updates the copy and queues the one result it must produce.
    class life_scoreboard;
        bit          grid_now [GRID_ROWS][GRID_COLS];
        logic [3:0]  survive_lo;
        logic [3:0]  survive_hi;
        logic [3:0]  birth_lo;
        logic [3:0]  birth_hi;
        t_out_item   awaited[$];
        int unsigned fail_count;

        function new();
            foreach (grid_now[r, c]) grid_now[r][c] = 1'b0;
            survive_lo = 4'd2;
            survive_hi = 4'd3;
            birth_lo   = 4'd3;
            birth_hi   = 4'd3;
            fail_count = 0;
        endfunction

        function void set_rule(input t_reg_idx idx, input logic [3:0] val);
            case (idx)
                REG_SURVIVE_LOW:  survive_lo = val;
                REG_SURVIVE_HIGH: survive_hi = val;
                REG_BIRTH_LOW:    birth_lo   = val;
                REG_BIRTH_HIGH:   birth_hi   = val;
                default: ;
            endcase
        endfunction

        // Cells off the grid count as dead.
        function int live_neighbours(input int r, input int c);
            int n;
            int rr;
            int cc;
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = r + dr;
                    cc = c + dc;
                    if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
                        rr < GRID_ROWS && cc < GRID_COLS) begin
                        n += grid_now[rr][cc];
                    end
                end
            end
            return n;
        endfunction

        // Work out the whole next generation before replacing the grid.
        function void advance_generation();
            bit grid_next [GRID_ROWS][GRID_COLS];
            int n;
            for (int r = 0; r < GRID_ROWS; r++) begin
                for (int c = 0; c < GRID_COLS; c++) begin
                    n = live_neighbours(r, c);
                    if (grid_now[r][c]) begin
                        grid_next[r][c] = (n >= survive_lo) && (n <= survive_hi);
                    end else begin
                        grid_next[r][c] = (n >= birth_lo) && (n <= birth_hi);
                    end
                end
            end
            grid_now = grid_next;
        endfunction

        function void note_input(input t_in_item it);
            t_out_item want;
            logic      on_grid;
            want.cell_alive = 1'b0;
            want.done_res   = 1'b1;
            on_grid = (it.cell_row < GRID_ROWS) && (it.cell_col < GRID_COLS);
            case (t_cmd'(it.cmd))
                CMD_WRITE: if (on_grid) grid_now[it.cell_row][it.cell_col] = it.set_alive;
                CMD_STEP:  advance_generation();
                CMD_READ:  if (on_grid) want.cell_alive = grid_now[it.cell_row][it.cell_col];
                CMD_NONE:  want.done_res = 1'b0;
                default: ;
            endcase
            awaited.push_back(want);
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $display("%0t: result %b arrived with nothing outstanding", $time, got);
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            if (got.cell_alive !== want.cell_alive) begin
                $display("%0t: cell_alive mismatch, expected %b, got %b",
                         $time, want.cell_alive, got.cell_alive);
                fail_count++;
            end
            if (got.done_res !== want.done_res) begin
                $display("%0t: done_res mismatch, expected %b, got %b",
                         $time, want.done_res, got.done_res);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    in_item;
    logic        empty;
    logic        pop;
    t_out_item   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    life_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             hold_req;
    int unsigned    cycle_count = 0;

    life_automaton_generation_step u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge; inputs only move on the falling edge,
    // so every value seen here is settled.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (push && !full) sb.note_input(in_item);
            if (pop && !empty) sb.check_result(out_item);
        end
    end

    // Result side: pop at random, or hold off for a long stretch when asked, so that
    // both internal queues fill and full goes high while the sender keeps offering.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one transaction, idling first at random, and hold it until taken.
    task automatic send_op(input t_cmd op, input logic [5:0] row, input logic [5:0] col,
                           input logic alive);
        t_in_item it;
        it.cmd       = op;
        it.cell_row  = row;
        it.cell_col  = col;
        it.set_alive = alive;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    // Drop push and wait until every outstanding transaction has returned.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value once pready is seen.
    task automatic write_rule(input t_reg_idx idx, input logic [3:0] val);
        logic [31:0] word;
        word      = $urandom();
        word[3:0] = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_rule(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_rules(input t_rules rules);
        write_rule(REG_SURVIVE_LOW,  rules.survive_low);
        write_rule(REG_SURVIVE_HIGH, rules.survive_high);
        write_rule(REG_BIRTH_LOW,    rules.birth_low);
        write_rule(REG_BIRTH_HIGH,   rules.birth_high);
    endtask

    // Corner of a small working window; favour the grid edges.
    function automatic int pick_base(input int span);
        case ($urandom_range(3))
            0:       return 0;
            1:       return span - WINDOW;
            default: return $urandom_range(span - WINDOW);
        endcase
    endfunction

    // Mostly well-formed runs: seed a window, step once or twice, read cells back.
    // One choice in ten sends a single noise transaction anywhere on the grid, unused command too.
    task automatic run_phase(input int n_items);
        int sent;
        int base_r;
        int base_c;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_op(t_cmd'($urandom_range(3)), 6'($urandom_range(63)),
                        6'($urandom_range(63)), 1'($urandom_range(1)));
                sent++;
            end else begin
                base_r = pick_base(GRID_ROWS);
                base_c = pick_base(GRID_COLS);
                repeat ($urandom_range(3, 8)) begin
                    send_op(CMD_WRITE, 6'(base_r + $urandom_range(WINDOW - 1)),
                            6'(base_c + $urandom_range(WINDOW - 1)),
                            $urandom_range(9) < 8);
                    sent++;
                end
                repeat ($urandom_range(1, 2)) begin
                    send_op(CMD_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                            1'($urandom_range(1)));
                    sent++;
                end
                repeat ($urandom_range(2, 5)) begin
                    send_op(CMD_READ, 6'(base_r + $urandom_range(WINDOW - 1)),
                            6'(base_c + $urandom_range(WINDOW - 1)),
                            1'($urandom_range(1)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        t_rules rule_sets[5];
        sb            = new();
        i_rst_n       = 1'b0;
        push          = 1'b0;
        in_item       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 66;

        // Standard B3/S23, then full survive range, then nothing survives (low bound
        // above eight) with birth on zero neighbours, then an inverted survive range
        // with an open birth range, then anything.
        rule_sets[0] = '{4'd2, 4'd3, 4'd3, 4'd3};
        rule_sets[1] = '{4'd0, 4'd15, 4'd8, 4'd8};
        rule_sets[2] = '{4'd9, 4'd15, 4'd0, 4'd0};
        rule_sets[3] = '{4'd5, 4'd2, 4'd3, 4'd15};
        rule_sets[4] = '{4'($urandom_range(15)), 4'($urandom_range(15)),
                         4'($urandom_range(15)), 4'($urandom_range(15))};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a cleared grid, the unused command, a blinker on the top edge,
        // a still block in the far corner, a cell set and cleared again, then steps.
        send_op(CMD_READ,  6'd0,  6'd0,  1'b1);
        send_op(CMD_NONE,  6'd63, 6'd63, 1'b1);
        send_op(CMD_WRITE, 6'd0,  6'd0,  1'b1);
        send_op(CMD_WRITE, 6'd0,  6'd1,  1'b1);
        send_op(CMD_WRITE, 6'd0,  6'd2,  1'b1);
        send_op(CMD_WRITE, 6'd62, 6'd62, 1'b1);
        send_op(CMD_WRITE, 6'd62, 6'd63, 1'b1);
        send_op(CMD_WRITE, 6'd63, 6'd62, 1'b1);
        send_op(CMD_WRITE, 6'd63, 6'd63, 1'b1);
        send_op(CMD_WRITE, 6'd31, 6'd31, 1'b1);
        send_op(CMD_WRITE, 6'd31, 6'd31, 1'b0);
        send_op(CMD_STEP,  6'd0,  6'd0,  1'b0);
        send_op(CMD_READ,  6'd0,  6'd1,  1'b0);
        send_op(CMD_READ,  6'd1,  6'd1,  1'b0);
        send_op(CMD_READ,  6'd0,  6'd0,  1'b0);
        send_op(CMD_READ,  6'd63, 6'd63, 1'b0);
        send_op(CMD_READ,  6'd31, 6'd31, 1'b0);
        send_op(CMD_STEP,  6'd63, 6'd63, 1'b1);
        send_op(CMD_READ,  6'd0,  6'd1,  1'b0);
        send_op(CMD_READ,  6'd62, 6'd62, 1'b0);

        // Random phases, each under its own rules; change rules only once drained.
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph < 2) ? 7  : (ph < 4) ? 66 : 0;
            recv_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 7  : 0;
            wait_drained();
            apply_rules(rule_sets[ph]);
            if (ph == 4) hold_req = 1'b1;
            run_phase(20);
        end

        // Drain, then let the clock run on to catch stray results.
        wait_drained();
        repeat (GRID_ROWS + 8) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
